// ===== rtl/forward_kinematics_chain_defines.svh =====
// assertion macros for the forward kinematics chain checker
// expects clk and rst_n in the scope of use
`ifndef FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`define FORWARD_KINEMATICS_CHAIN_DEFINES_SVH

// same-cycle implication
`define FKC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fkc check failed");

// next-cycle implication
`define FKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fkc check failed");

`endif

// ===== rtl/fkc_pkg.sv =====
// shared types and constants for the forward kinematics chain
// no dependencies
`default_nettype none
package fkc_pkg;

  localparam int ELEMS = 12;
  localparam int JW    = 5;
  localparam int EW    = 4;

  localparam logic [1:0] REQ_LINK = 2'd0;
  localparam logic [1:0] REQ_BASE = 2'd1;
  localparam logic [1:0] REQ_POSE = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [JW-1:0]       joint;
    logic [EW-1:0]       elem;
    logic signed [31:0]  value;
    logic signed [17:0]  sine;
    logic signed [17:0]  cosine;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/fkc_ram.sv =====
// generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none
module fkc_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/fkc_front.sv =====
// front end: accepts items, drops invalid ones, queues commands
// depends on fkc_pkg
`default_nettype none
module fkc_front
  import fkc_pkg::*;
#(
  parameter int MAX_JOINTS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [JW-1:0]      in_joint_index,
  input  wire logic [EW-1:0]      in_element_index,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic signed [17:0] in_sine_q,
  input  wire logic signed [17:0] in_cosine_q,
  output cmd_t                    cmd,
  output logic                    cmd_valid,
  input  wire logic               cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       joint_ok, elem_ok, keep, push;

  assign joint_ok = (in_joint_index != '0) && (in_joint_index <= JW'(MAX_JOINTS));
  assign elem_ok  = in_element_index < EW'(ELEMS);

  always_comb begin
    unique case (in_req_type)
      REQ_LINK: keep = joint_ok && elem_ok;
      REQ_BASE: keep = elem_ok;
      REQ_POSE: keep = joint_ok;
      default:  keep = 1'b0;
    endcase
  end

  assign busy      = cnt_r == 2'd2;
  assign push      = start && !busy && keep;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{kind: in_req_type, joint: in_joint_index,
                         elem: in_element_index, value: in_element_value,
                         sine: in_sine_q, cosine: in_cosine_q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fkc_back.sv =====
// back end: table loads, link rotation and pose product on one multiplier
// depends on fkc_pkg and fkc_ram
`default_nettype none
module fkc_back
  import fkc_pkg::*;
#(
  parameter int MAX_JOINTS = 4,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_pop,
  output logic             out_valid,
  output logic [JW-1:0]    out_pose_joint,
  output logic [EW-1:0]    out_pose_element,
  output logic signed [31:0] out_pose_value,
  output logic             out_last
);

  localparam int DEPTH = MAX_JOINTS * ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = 67;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FETCH = 2'd1;
  localparam logic [1:0] PH_ROT   = 2'd2;
  localparam logic [1:0] PH_POSE  = 2'd3;

  localparam logic signed [31:0]      ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (FRAC_BITS - 1);

  function automatic logic [8:0] addr_of(input logic [JW-1:0] j, input logic [EW-1:0] el);
    logic [JW-1:0] jm;
    jm = j - JW'(1);
    return 9'({jm, 3'b000}) + 9'({jm, 2'b00}) + 9'(el);
  endfunction

  logic [1:0]          ph_r;
  logic [3:0]          cnt_r, e_r;
  logic [1:0]          k_r;
  logic [JW-1:0]       joint_r;
  logic signed [17:0]  s_r, c_r;

  logic signed [31:0]  base_r [ELEMS];
  logic signed [31:0]  lk_r   [8];
  logic signed [31:0]  h_r    [ELEMS];
  logic signed [31:0]  par_r  [ELEMS];

  logic [DEPTH-1:0]    lvld_r, pvld_r;
  logic                lvq_r, pvq_r, rd_go_r;
  logic [3:0]          rd_idx_r;

  logic                link_we, pose_we;
  logic [AW-1:0]       link_waddr, link_raddr, pose_waddr, pose_raddr;
  logic [31:0]         link_rdata, pose_rdata;
  logic signed [31:0]  lval, pval;

  logic                iss_v, iss_first, iss_last, iss_sub, iss_pose;
  logic [3:0]          iss_dst;
  logic signed [31:0]  a_op, b_op;
  logic [1:0]          term, col, last_k;
  logic [3:0]          hidx;

  logic                v2_r, first2_r, last2_r, sub2_r, pose2_r;
  logic [3:0]          dst2_r;
  logic signed [63:0]  p_r;
  logic signed [ACC_W-1:0] acc_r, acc_sum, acc_base, pext;
  logic signed [31:0]  res;
  logic                res_v;

  assign cmd_pop    = (ph_r == PH_IDLE) && cmd_valid;
  assign link_we    = cmd_pop && (cmd.kind == REQ_LINK);
  assign link_waddr = AW'(addr_of(cmd.joint, cmd.elem));
  assign link_raddr = AW'(addr_of(joint_r, cnt_r));
  assign pose_raddr = AW'(addr_of(joint_r - JW'(1), cnt_r));
  assign pose_waddr = AW'(addr_of(joint_r, dst2_r));
  assign res_v      = v2_r && last2_r;
  assign pose_we    = res_v && pose2_r;

  fkc_ram #(.W(32), .DEPTH(DEPTH)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(cmd.value),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  fkc_ram #(.W(32), .DEPTH(DEPTH)) u_pose_ram (
    .clk(clk), .we(pose_we), .waddr(pose_waddr), .wdata(res),
    .raddr(pose_raddr), .rdata(pose_rdata)
  );

  assign lval = lvq_r ? $signed(link_rdata) : 32'sd0;
  assign pval = (joint_r == JW'(1)) ? base_r[rd_idx_r] :
                (pvq_r ? $signed(pose_rdata) : 32'sd0);

  // operand select for the shared multiplier
  always_comb begin
    iss_v     = 1'b0;
    iss_first = 1'b0;
    iss_last  = 1'b0;
    iss_sub   = 1'b0;
    iss_pose  = 1'b0;
    iss_dst   = 4'd0;
    a_op      = 32'sd0;
    b_op      = 32'sd0;
    term      = cnt_r[1:0];
    col       = e_r[1:0];
    last_k    = (e_r[1:0] == 2'd3) ? 2'd3 : 2'd2;
    hidx      = (k_r == 2'd3) ? 4'd0 : {k_r, e_r[1:0]};
    unique case (ph_r)
      PH_ROT: begin
        col       = cnt_r[3:2];
        iss_v     = 1'b1;
        a_op      = term[0] ? 32'(s_r) : 32'(c_r);
        b_op      = lk_r[{term[0] ^ term[1], col}];
        iss_first = !term[0];
        iss_last  = term[0];
        iss_sub   = term == 2'd1;
        iss_dst   = {1'b0, term[1], col};
      end
      PH_POSE: begin
        iss_v     = 1'b1;
        iss_pose  = 1'b1;
        a_op      = par_r[{e_r[3:2], k_r}];
        b_op      = (k_r == 2'd3) ? ONE_Q : h_r[hidx];
        iss_first = k_r == 2'd0;
        iss_last  = k_r == last_k;
        iss_dst   = e_r;
      end
      default: begin
        iss_v = 1'b0;
      end
    endcase
  end

  // accumulate, round and saturate
  always_comb begin
    pext     = ACC_W'(p_r);
    acc_base = first2_r ? HALF : acc_r;
    acc_sum  = sub2_r ? acc_base - pext : acc_base + pext;
    if (&acc_sum[ACC_W-1:FRAC_BITS+31] || ~|acc_sum[ACC_W-1:FRAC_BITS+31]) begin
      res = acc_sum[FRAC_BITS+31:FRAC_BITS];
    end else begin
      res = acc_sum[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= 64'(a_op) * 64'(b_op);
    first2_r <= iss_first;
    last2_r  <= iss_last;
    sub2_r   <= iss_sub;
    pose2_r  <= iss_pose;
    dst2_r   <= iss_dst;
    rd_idx_r <= cnt_r;
    lvq_r    <= lvld_r[link_raddr];
    pvq_r    <= pvld_r[pose_raddr];
    if (v2_r) begin
      acc_r <= acc_sum;
    end
    if (res_v && !pose2_r) begin
      h_r[dst2_r] <= res;
    end
    if (rd_go_r) begin
      if (rd_idx_r < 4'd8) begin
        lk_r[rd_idx_r[2:0]] <= lval;
      end else begin
        h_r[rd_idx_r] <= lval;
      end
      par_r[rd_idx_r] <= pval;
    end
    if (cmd_pop && cmd.kind == REQ_POSE) begin
      joint_r <= cmd.joint;
      s_r     <= cmd.sine;
      c_r     <= cmd.cosine;
    end
    out_pose_joint   <= joint_r;
    out_pose_element <= dst2_r;
    out_pose_value   <= res;
    out_last         <= pose_we && (dst2_r == EW'(ELEMS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      cnt_r     <= 4'd0;
      e_r       <= 4'd0;
      k_r       <= 2'd0;
      v2_r      <= 1'b0;
      rd_go_r   <= 1'b0;
      out_valid <= 1'b0;
      lvld_r    <= '0;
      pvld_r    <= '0;
      for (int i = 0; i < ELEMS; i++) begin
        base_r[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q : 32'sd0;
      end
    end else begin
      v2_r      <= iss_v;
      out_valid <= pose_we;
      rd_go_r   <= (ph_r == PH_FETCH) && (cnt_r < 4'd12);
      if (link_we) begin
        lvld_r[link_waddr] <= 1'b1;
      end
      if (pose_we) begin
        pvld_r[pose_waddr] <= 1'b1;
      end
      unique case (ph_r)
        PH_IDLE: begin
          if (cmd_pop) begin
            if (cmd.kind == REQ_BASE) begin
              base_r[cmd.elem] <= cmd.value;
            end
            if (cmd.kind == REQ_POSE) begin
              ph_r  <= PH_FETCH;
              cnt_r <= 4'd0;
            end
          end
        end
        PH_FETCH: begin
          if (cnt_r == 4'd12) begin
            ph_r  <= PH_ROT;
            cnt_r <= 4'd0;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        PH_ROT: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            ph_r <= PH_POSE;
            e_r  <= 4'd0;
            k_r  <= 2'd0;
          end
        end
        PH_POSE: begin
          if (k_r == last_k) begin
            k_r <= 2'd0;
            if (e_r == EW'(ELEMS - 1)) begin
              ph_r <= PH_IDLE;
            end else begin
              e_r <= e_r + 4'd1;
            end
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/forward_kinematics_chain.sv =====
// top level of the forward kinematics chain: front end, queue and back end
// depends on fkc_pkg, fkc_front and fkc_back
//
// A load item is written to its table as the back end pops it. In the back end a
// compute item fetches the link and parent rows from the tables, then does 16
// products for the z rotation and 39 for the pose product, all on one shared
// 32x32 multiplier that does one product per cycle. Its twelve pose elements
// come out in ascending order, one strobe each, never back to back;
// the receiver must take each in the cycle it is shown. A two-entry queue
// sits between front and back, and busy is high only while it is full.
`default_nettype none
module forward_kinematics_chain
  import fkc_pkg::*;
#(
  parameter int MAX_JOINTS = 4,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [JW-1:0]      in_joint_index,
  input  wire logic [EW-1:0]      in_element_index,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic signed [17:0] in_sine_q,
  input  wire logic signed [17:0] in_cosine_q,
  output logic                    out_valid,
  output logic [JW-1:0]           out_pose_joint,
  output logic [EW-1:0]           out_pose_element,
  output logic signed [31:0]      out_pose_value,
  output logic                    out_last
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  fkc_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_joint_index(in_joint_index),
    .in_element_index(in_element_index), .in_element_value(in_element_value),
    .in_sine_q(in_sine_q), .in_cosine_q(in_cosine_q),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  fkc_back #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
    .out_valid(out_valid), .out_pose_joint(out_pose_joint),
    .out_pose_element(out_pose_element), .out_pose_value(out_pose_value),
    .out_last(out_last)
  );

endmodule
`default_nettype wire

// ===== rtl/fkc_checker.sv =====
// port-level checks for the forward kinematics chain, bound to the top level
// depends on fkc_pkg and forward_kinematics_chain_defines.svh
`default_nettype none
`include "forward_kinematics_chain_defines.svh"
module fkc_checker
  import fkc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic [JW-1:0]      out_pose_joint,
  input wire logic [EW-1:0]      out_pose_element,
  input wire logic signed [31:0] out_pose_value,
  input wire logic               out_last
);

  // last item of a pose only on element eleven
  `FKC_ASSERT_NOW(a_last_elem, out_last, out_valid && out_pose_element == 4'd11)
  // each element needs several products, so strobes never touch
  `FKC_ASSERT_NEXT(a_spaced, out_valid, !out_valid)
  // a pose element never names joint zero
  `FKC_ASSERT_NOW(a_joint_nz, out_valid, out_pose_joint != 5'd0)
  // element numbers stay within the top three rows
  `FKC_ASSERT_NOW(a_elem_range, out_valid, out_pose_element <= 4'd11)
  // a shown value is always known
  `FKC_ASSERT_NOW(a_value_known, out_valid, !$isunknown(out_pose_value))

endmodule

bind forward_kinematics_chain fkc_checker u_fkc_checker (.*);
`default_nettype wire
